>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

   localparam int ADDR_W       = 48;
   localparam int PAGES_W      = 16;
   localparam int STATUS_W     = 3;
   localparam int MAX_SLOTS    = 16;
   localparam int PAGE_BYTES   = 4096;
   localparam int HEADER_BYTES = 32;

   localparam int SLOT_IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int SLOT_CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int PAGE_BYTES_W = $clog2(PAGE_BYTES + 1);
   localparam int PROD_W       = PAGES_W + PAGE_BYTES_W;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED    = 3'd0,
      ST_NEW       = 3'd1,
      ST_FREED     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } ffra_status_type;

   typedef struct packed {
      ffra_status_type     status;
      logic [ADDR_W-1:0]   data_address;
      logic [PAGES_W-1:0]  granted_pages;
   } ffra_result_type;

   typedef struct packed {
      logic                  en;
      logic [SLOT_IDX_W-1:0] idx;
      logic [ADDR_W-1:0]     base;
      logic [PAGES_W-1:0]    pages;
   } ffra_slot_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [PAGES_W-1:0] pages;
   } ffra_slot_rd_type;

endpackage

>>> rtl/core/first_fit_region_allocator.sv
// A request scans the slot table from slot 0 until a hit, each further slot adding
// to the time; an allocate with no fit appends after the full scan unless full.
// One request at a time: the next is taken only once the engine is back in S_IDLE,
// after S_DONE has passed the result to the output register once that is free.
// The scan reads one slot per cycle through the slot memory's single read port.
// Reset (synchronous) empties the table and clears region_base; no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit region allocator with a bump address for appended regions.
// ----------------------------------------------------------------------------
module first_fit_region_allocator
   import ffra_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [PAGES_W-1:0]  req_request_pages,
   input  logic [ADDR_W-1:0]   req_free_address,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_data_address,
   output logic [PAGES_W-1:0]  rsp_granted_pages,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ADDR_W-1:0]   csr_region_base
);

   logic [ADDR_W-1:0] region_base_ff, region_base_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffra_result_type   rsp_ff, rsp_in;
   ffra_result_type   res;
   logic              res_valid;
   logic              idle;
   logic              out_ready;
   logic              start;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign start     = req_valid && idle;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   ffra_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .mode          (req_mode),
      .request_pages (req_request_pages),
      .free_address  (req_free_address),
      .region_base   (region_base_ff),
      .out_ready     (out_ready),
      .idle          (idle),
      .res_valid     (res_valid),
      .res           (res)
   );

   always_comb begin
      region_base_in = (csr_valid && csr_ready) ? csr_region_base : region_base_ff;
      rsp_valid_in   = res_valid || (rsp_valid_ff && rsp_stall);
      rsp_in         = res_valid ? res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         region_base_ff <= region_base_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_data_address  = rsp_ff.data_address;
   assign rsp_granted_pages = rsp_ff.granted_pages;

endmodule

>>> rtl/core/ffra_slot_store.sv
// ----------------------------------------------------------------------------
// ffra_slot_store
// Slot table memory: data base address and page count of each region,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffra_slot_store
   import ffra_pkg::*;
(
   input  logic                  clock,
   input  ffra_slot_wr_type      wr,
   input  logic                  rd_en,
   input  logic [SLOT_IDX_W-1:0] rd_idx,
   output ffra_slot_rd_type      rd_data
);

   logic [ADDR_W-1:0]  slot_base_ff  [MAX_SLOTS];
   logic [PAGES_W-1:0] slot_pages_ff [MAX_SLOTS];
   ffra_slot_rd_type   rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_base_ff[wr.idx]  <= wr.base;
         slot_pages_ff[wr.idx] <= wr.pages;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.base  <= slot_base_ff[rd_idx];
         rd_data_ff.pages <= slot_pages_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ffra_engine.sv
// ----------------------------------------------------------------------------
// ffra_engine
// Sequencer that scans the slot table one entry per cycle through a shared
// compare unit, then claims or frees a slot, appends a new region or reports a failure.
// ----------------------------------------------------------------------------
module ffra_engine
   import ffra_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                mode,
   input  logic [PAGES_W-1:0]  request_pages,
   input  logic [ADDR_W-1:0]   free_address,
   input  logic [ADDR_W-1:0]   region_base,
   input  logic                out_ready,
   output logic                idle,
   output logic                res_valid,
   output ffra_result_type     res
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APP_BASE,
      S_APP_BUMP,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOT_CNT_W-1:0] idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [SLOT_IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic                  mode_ff, mode_in;
   logic [PAGES_W-1:0]    pages_ff, pages_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [MAX_SLOTS-1:0]  used_ff, used_in;
   logic [SLOT_CNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]     bump_ff, bump_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   ffra_result_type       res_ff, res_in;

   ffra_slot_wr_type      slot_wr;
   ffra_slot_rd_type      slot_rd;
   logic                  rd_en;
   logic                  more_slots;
   logic                  hit;
   logic [ADDR_W-1:0]     bump_src;
   logic [ADDR_W-1:0]     base_sum;

   ffra_slot_store u_slot_store (
      .clock   (clock),
      .wr      (slot_wr),
      .rd_en   (rd_en),
      .rd_idx  (idx_ff[SLOT_IDX_W-1:0]),
      .rd_data (slot_rd)
   );

   // Shared compare unit: address match for a free, fit test for an allocate.
   always_comb begin
      if (mode_ff == MODE_FREE) begin
         hit = pend_ff && (slot_rd.base == addr_ff);
      end else begin
         hit = pend_ff && !used_ff[pend_idx_ff] && (slot_rd.pages >= pages_ff);
      end
   end

   // Until the first region exists, the bump address tracks the base register.
   assign bump_src   = (count_ff == '0) ? region_base : bump_ff;
   assign base_sum   = bump_src + ADDR_W'(HEADER_BYTES);
   assign more_slots = idx_ff < count_ff;
   assign rd_en      = (state_ff == S_SCAN) && more_slots;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      mode_in     = mode_ff;
      pages_in    = pages_ff;
      addr_in     = addr_ff;
      used_in     = used_ff;
      count_in    = count_ff;
      bump_in     = bump_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      slot_wr     = '0;
      res_valid   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = mode;
               pages_in = request_pages;
               addr_in  = free_address;
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               pend_in = 1'b0;
               if (mode_ff == MODE_FREE) begin
                  used_in[pend_idx_ff] = 1'b0;
                  res_in = '{ST_FREED, addr_ff, '0};
               end else begin
                  used_in[pend_idx_ff] = 1'b1;
                  res_in = '{ST_REUSED, slot_rd.base, slot_rd.pages};
               end
               state_in = S_DONE;
            end else if (!pend_ff && !more_slots) begin
               if (mode_ff == MODE_FREE) begin
                  res_in   = '{ST_NOT_FOUND, '0, '0};
                  state_in = S_DONE;
               end else if (count_ff == SLOT_CNT_W'(MAX_SLOTS)) begin
                  res_in   = '{ST_FULL, '0, '0};
                  state_in = S_DONE;
               end else begin
                  state_in = S_APP_BASE;
               end
            end else begin
               // The read issued now is tested in the next cycle.
               pend_in     = rd_en;
               pend_idx_in = idx_ff[SLOT_IDX_W-1:0];
               if (rd_en) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_APP_BASE: begin
            slot_wr.en    = 1'b1;
            slot_wr.idx   = count_ff[SLOT_IDX_W-1:0];
            slot_wr.base  = base_sum;
            slot_wr.pages = pages_ff;
            used_in[count_ff[SLOT_IDX_W-1:0]] = 1'b1;
            prod_in  = PROD_W'(pages_ff) * PROD_W'(PAGE_BYTES);
            res_in   = '{ST_NEW, base_sum, pages_ff};
            state_in = S_APP_BUMP;
         end
         S_APP_BUMP: begin
            bump_in  = bump_src + ADDR_W'(prod_ff);
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         used_ff  <= used_in;
         count_ff <= count_in;
      end
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      mode_ff     <= mode_in;
      pages_ff    <= pages_in;
      addr_ff     <= addr_in;
      bump_ff     <= bump_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign res  = res_ff;

endmodule

>>> rtl/core/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_props
// Port-level checks of the region allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffra_props
   import ffra_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ADDR_W-1:0]   rsp_data_address,
   input logic [PAGES_W-1:0]  rsp_granted_pages
);

   // A request is worked on by the engine after it is taken, so the port stalls after a transfer.
`ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "req not stalled after transfer")
`ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "stalled rsp dropped")
`ASSERT_HOLDS(a_status_range, clock, reset, !rsp_valid || (rsp_status <= ST_FULL), "status code out of range")
`ASSERT_HOLDS(a_pages_zero, clock, reset, !rsp_valid || rsp_status == ST_REUSED || rsp_status == ST_NEW || rsp_granted_pages == '0, "pages given without grant")
`ASSERT_HOLDS(a_addr_zero, clock, reset, !rsp_valid || !(rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL) || rsp_data_address == '0, "address on failed request")

endmodule

bind first_fit_region_allocator ffra_props u_ffra_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_data_address  (rsp_data_address),
   .rsp_granted_pages (rsp_granted_pages)
);

>>> tb/sv/ffra_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request, result and register channels of the region allocator.
// It keeps its own region table, predicts each result and compares it with
// the result that the block returns.
// ----------------------------------------------------------------------------
module ffra_checker
   import ffra_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_mode,
   input  logic [PAGES_W-1:0]  req_request_pages,
   input  logic [ADDR_W-1:0]   req_free_address,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [ADDR_W-1:0]   rsp_data_address,
   input  logic [PAGES_W-1:0]  rsp_granted_pages,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [ADDR_W-1:0]   csr_region_base,
   output int                  mismatch_count,
   output int                  pending_count
);

   logic [ADDR_W-1:0]  region_base_reg;
   logic [ADDR_W-1:0]  bump_addr;
   logic [ADDR_W-1:0]  table_base  [MAX_SLOTS];
   logic [PAGES_W-1:0] table_pages [MAX_SLOTS];
   logic               table_used  [MAX_SLOTS];
   int                 table_count;
   ffra_result_type    expected_outcomes[$];
   int                 errors = 0;

   // Applies one request to the table copy and returns the result it should give.
   function automatic ffra_result_type apply_region_request(
      input logic               mode,
      input logic [PAGES_W-1:0] pages,
      input logic [ADDR_W-1:0]  addr
   );
      ffra_result_type   res;
      logic [ADDR_W-1:0] start;
      int                i;
      res.status        = ST_NOT_FOUND;
      res.data_address  = '0;
      res.granted_pages = '0;
      if (mode == MODE_ALLOC) begin
         for (i = 0; i < table_count; i++) begin
            if (!table_used[i] && table_pages[i] >= pages) begin
               table_used[i]     = 1'b1;
               res.status        = ST_REUSED;
               res.data_address  = table_base[i];
               res.granted_pages = table_pages[i];
               return res;
            end
         end
         if (table_count >= MAX_SLOTS) begin
            res.status = ST_FULL;
            return res;
         end
         // The base register only counts until the first region exists.
         start = (table_count == 0) ? region_base_reg : bump_addr;
         table_base[table_count]  = start + ADDR_W'(HEADER_BYTES);
         table_pages[table_count] = pages;
         table_used[table_count]  = 1'b1;
         bump_addr = start + ADDR_W'(pages) * ADDR_W'(PAGE_BYTES);
         res.status        = ST_NEW;
         res.data_address  = table_base[table_count];
         res.granted_pages = pages;
         table_count++;
      end else begin
         for (i = 0; i < table_count; i++) begin
            if (table_base[i] == addr) begin
               table_used[i]    = 1'b0;
               res.status       = ST_FREED;
               res.data_address = addr;
               return res;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      ffra_result_type want;
      if (reset) begin
         region_base_reg = '0;
         bump_addr       = '0;
         table_count     = 0;
         foreach (table_used[i]) table_used[i] = 1'b0;
         expected_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) region_base_reg = csr_region_base;
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result: status %0d, address %h, pages %0d",
                           $time, rsp_status, rsp_data_address, rsp_granted_pages);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_data_address !== want.data_address ||
                   rsp_granted_pages !== want.granted_pages) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: result mismatch: expected status %0d, address %h, ",
                               "pages %0d; got status %0d, address %h, pages %0d"},
                              $time, want.status, want.data_address, want.granted_pages,
                              rsp_status, rsp_data_address, rsp_granted_pages);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_outcomes.push_back(
               apply_region_request(req_mode, req_request_pages, req_free_address));
      end
      pending_count  <= expected_outcomes.size();
      mismatch_count <= errors;
   end

endmodule

>>> tb/sv/first_fit_region_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_tb
// Drives the region allocator with a directed opening sequence, then with
// random allocate and free requests over several base register settings,
// with random idle bursts on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_tb;
   import ffra_pkg::*;

   typedef enum int {
      PH_DIRECTED,
      PH_MIXED,
      PH_PRESSURE,
      PH_SPREAD,
      PH_STEADY
   } phase_type;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 2 * MAX_SLOTS + 12;
   localparam int LONG_HOLD     = 400;

   localparam logic [ADDR_W-1:0] ADDR_ONES     = '1;
   localparam logic [ADDR_W-1:0] DIRECTED_BASE = 48'hFFFF_FFFF_E000;
   localparam logic [ADDR_W-1:0] FIRST_DATA    = DIRECTED_BASE + ADDR_W'(HEADER_BYTES);
   localparam logic [ADDR_W-1:0] SECOND_DATA   = DIRECTED_BASE + ADDR_W'(PAGE_BYTES) +
                                                 ADDR_W'(HEADER_BYTES);
   // The largest region pushes the bump address past the top of the address space.
   localparam logic [ADDR_W-1:0] WRAPPED_BUMP  = DIRECTED_BASE + ADDR_W'(PAGE_BYTES) +
                                                 ADDR_W'(16'hFFFF) * ADDR_W'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] SHARED_DATA   = WRAPPED_BUMP + ADDR_W'(HEADER_BYTES);

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic                req_mode          = MODE_ALLOC;
   logic [PAGES_W-1:0]  req_request_pages = '0;
   logic [ADDR_W-1:0]   req_free_address  = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_data_address;
   logic [PAGES_W-1:0]  rsp_granted_pages;
   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic [ADDR_W-1:0]   csr_region_base   = '0;

   int                  mismatch_count;
   int                  pending_count;
   phase_type           phase_no          = PH_DIRECTED;
   int                  stall_left        = 0;
   logic                long_hold_done    = 1'b0;
   int                  cycle_count       = 0;
   logic [ADDR_W-1:0]   known_bases[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   first_fit_region_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_request_pages (req_request_pages),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_address  (rsp_data_address),
      .rsp_granted_pages (rsp_granted_pages),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_region_base   (csr_region_base)
   );

   ffra_checker CHECK (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_request_pages (req_request_pages),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_address  (rsp_data_address),
      .rsp_granted_pages (rsp_granted_pages),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_region_base   (csr_region_base),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   // Result side: random stall bursts, plus one long hold-off so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (phase_no == PH_PRESSURE && !long_hold_done) begin
         long_hold_done <= 1'b1;
         stall_left     <= LONG_HOLD - 1;
         rsp_stall      <= 1'b1;
      end else if (phase_no != PH_STEADY && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Region addresses handed out so far, used to aim free requests at real regions.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_NEW)
         known_bases.push_back(rsp_data_address);
   end

   task automatic write_base(input logic [ADDR_W-1:0] value, input logic more);
      csr_valid       <= 1'b1;
      csr_region_base <= value;
      do @(posedge clock); while (!csr_ready);
      if (!more) csr_valid <= 1'b0;
   endtask

   task automatic send_request(
      input logic               mode,
      input logic [PAGES_W-1:0] pages,
      input logic [ADDR_W-1:0]  addr
   );
      if (phase_no != PH_STEADY && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_request_pages <= pages;
      req_free_address  <= addr;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_requests(input int count);
      int                 pick;
      logic [PAGES_W-1:0] pages;
      logic [ADDR_W-1:0]  addr;
      repeat (count) begin
         pick  = $urandom_range(0, 99);
         addr  = ADDR_W'({$urandom, $urandom});
         pages = PAGES_W'($urandom);
         if (pick % 10 >= 2)
            pages = (pick % 10 < 4) ? pages >> $urandom_range(0, 15)
                                    : PAGES_W'($urandom_range(1, 8));
         if (pick < 50)
            send_request(MODE_ALLOC, pages, addr);
         else if (pick < 92 && known_bases.size() != 0)
            send_request(MODE_FREE, pages,
                         known_bases[$urandom_range(0, known_bases.size() - 1)]);
         else
            send_request(MODE_FREE, pages, addr);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("first_fit_region_allocator test failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Only the last write before the first region is created takes effect.
      write_base('0, 1'b1);
      write_base(ADDR_ONES, 1'b1);
      write_base(DIRECTED_BASE, 1'b0);

      send_request(MODE_ALLOC, 16'd1, ADDR_ONES);
      send_request(MODE_ALLOC, 16'hFFFF, '0);
      // A zero-page append leaves the bump address where it is.
      send_request(MODE_ALLOC, 16'd0, '0);
      send_request(MODE_FREE, 16'hFFFF, FIRST_DATA);
      send_request(MODE_FREE, 16'd0, FIRST_DATA);
      send_request(MODE_FREE, 16'd0, '0);
      send_request(MODE_FREE, 16'd1, ADDR_ONES);
      // This append lands on the same data base as the zero-page region.
      send_request(MODE_ALLOC, 16'd2, '0);
      send_request(MODE_ALLOC, 16'd1, '0);
      send_request(MODE_FREE, 16'd0, SHARED_DATA);
      send_request(MODE_ALLOC, 16'd0, '0);
      repeat (MAX_SLOTS - 4) send_request(MODE_ALLOC, PAGES_W'($urandom_range(1, 12)), '0);
      send_request(MODE_ALLOC, 16'd1, '0);
      send_request(MODE_FREE, 16'd0, SECOND_DATA);
      send_request(MODE_ALLOC, 16'hFFFF, '0);
      wait_idle();

      phase_no <= PH_MIXED;
      write_base(ADDR_ONES, 1'b0);
      random_requests(450);
      wait_idle();

      phase_no <= PH_PRESSURE;
      write_base('0, 1'b0);
      random_requests(450);
      wait_idle();

      phase_no <= PH_SPREAD;
      write_base(ADDR_W'({$urandom, $urandom}), 1'b0);
      random_requests(450);
      wait_idle();

      phase_no <= PH_STEADY;
      write_base(ADDR_W'({$urandom, $urandom}), 1'b0);
      random_requests(400);
      wait_idle();

      if (mismatch_count == 0 && pending_count == 0)
         $display("first_fit_region_allocator test passed");
      else
         $display("first_fit_region_allocator test failed");
      $finish;
   end

endmodule
